// ===== hw/rtl/kscd_pkg.sv =====
// kscd_pkg: shared types, constants and register indexes of the scancode decoder
// no dependencies; imported by kscd_decode, kscd_fifo, keyboard_scancode_decoder_top and the testbench

package kscd_pkg;

   localparam int FIFO_DEPTH = 16;
   localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

   localparam logic [7:0] RELEASE_PREFIX_RST  = 8'hF0;
   localparam logic [7:0] EXTENDED_PREFIX_RST = 8'hE0;
   localparam logic [7:0] SHIFT_CODE_RST      = 8'h12;
   localparam logic [7:0] ALT_CODE_RST        = 8'h11;
   localparam logic [7:0] CTL_CODE_RST        = 8'h14;

   typedef enum logic [2:0] {
      CSR_RELEASE_PREFIX  = 3'd0,
      CSR_EXTENDED_PREFIX = 3'd1,
      CSR_SHIFT_CODE      = 3'd2,
      CSR_ALT_CODE        = 3'd3,
      CSR_CTL_CODE        = 3'd4
   } csr_index_type;

   // modifier bit order: bit0 shift, bit1 alt, bit2 ctl
   localparam logic [2:0] MOD_SHIFT = 3'b001;
   localparam logic [2:0] MOD_ALT   = 3'b010;
   localparam logic [2:0] MOD_CTL   = 3'b100;
   localparam logic [2:0] MOD_NONE  = 3'b000;

   typedef struct packed {
      logic       is_extended;
      logic       is_release;
      logic [2:0] mods;
      logic [7:0] code;
   } key_entry_type;

   typedef struct packed {
      logic [7:0] release_prefix;
      logic [7:0] extended_prefix;
      logic [7:0] shift_code;
      logic [7:0] alt_code;
      logic [7:0] ctl_code;
   } cfg_type;

   typedef struct packed {
      logic          key_req;
      logic          pop_en;
      key_entry_type entry;
   } dec_type;

   typedef struct packed {
      logic          key_valid;
      logic          overflow;
      key_entry_type entry;
   } rsp_type;

endpackage

// ===== hw/rtl/kscd_decode.sv =====
// kscd_decode: prefix flags, modifier state and classification of one received byte
// depends on kscd_pkg

module kscd_decode
   import kscd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  cfg_type    cfg,
   input  logic       byte_valid,
   input  logic [7:0] scan_byte,
   output dec_type    dec
);

   logic       rel_ff, rel_in;
   logic       ext_ff, ext_in;
   logic [2:0] mod_ff, mod_in;
   logic [2:0] mask;

   always_comb begin
      if (scan_byte == cfg.shift_code) begin
         mask = MOD_SHIFT;
      end else if (scan_byte == cfg.alt_code) begin
         mask = MOD_ALT;
      end else if (scan_byte == cfg.ctl_code) begin
         mask = MOD_CTL;
      end else begin
         mask = MOD_NONE;
      end
   end

   always_comb begin
      rel_in      = rel_ff;
      ext_in      = ext_ff;
      mod_in      = mod_ff;
      dec.key_req = 1'b0;
      dec.pop_en  = 1'b1;
      dec.entry.is_extended = ext_ff;
      dec.entry.is_release  = rel_ff;
      dec.entry.mods        = mod_ff;
      dec.entry.code        = scan_byte;
      if (byte_valid) begin
         if (rel_ff && (mask != MOD_NONE)) begin
            // modifier released: tick ends here
            rel_in     = 1'b0;
            mod_in     = mod_ff & ~mask;
            dec.pop_en = 1'b0;
         end else begin
            rel_in = 1'b0;
            ext_in = 1'b0;
            if (scan_byte == cfg.extended_prefix) begin
               ext_in = 1'b1;
            end else if (scan_byte == cfg.release_prefix) begin
               rel_in = 1'b1;
            end else if (mask != MOD_NONE) begin
               mod_in = mod_ff | mask;
            end else begin
               dec.key_req = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rel_ff <= 1'b0;
         ext_ff <= 1'b0;
         mod_ff <= MOD_NONE;
      end else if (step) begin
         rel_ff <= rel_in;
         ext_ff <= ext_in;
         mod_ff <= mod_in;
      end
   end

endmodule

// ===== hw/rtl/kscd_fifo.sv =====
// kscd_fifo: key queue with pointers, fill count, bypass and the result register
// depends on kscd_pkg; driven by kscd_decode through dec_type

module kscd_fifo
   import kscd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    step,
   input  dec_type dec,
   output rsp_type rsp
);

   key_entry_type mem [FIFO_DEPTH];

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             full;
   logic             push;
   logic             pop;
   logic             ovf;
   logic [CNT_W-1:0] count_push;
   rsp_type          rsp_ff;

   always_comb begin
      full       = (count_ff >= CNT_W'(FIFO_DEPTH));
      push       = dec.key_req && !full;
      ovf        = dec.key_req && full;
      count_push = count_ff + CNT_W'(push);
      pop        = dec.pop_en && (count_push != '0);
      count_in   = count_push - CNT_W'(pop);
      wr_ptr_in  = wr_ptr_ff;
      rd_ptr_in  = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else if (step) begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && push) begin
         mem[wr_ptr_ff] <= dec.entry;
      end
   end

   // empty queue hands the new key straight through
   always_ff @(posedge clock) begin
      if (step) begin
         rsp_ff.key_valid <= pop;
         rsp_ff.overflow  <= ovf;
         if (!pop) begin
            rsp_ff.entry <= '0;
         end else if (count_ff == '0) begin
            rsp_ff.entry <= dec.entry;
         end else begin
            rsp_ff.entry <= mem[rd_ptr_ff];
         end
      end
   end

   assign rsp = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(FIFO_DEPTH))
      else $error("fill count beyond depth");

   a_ptr_bound: assert property (@(posedge clock) disable iff (reset)
      (wr_ptr_ff <= PTR_W'(FIFO_DEPTH - 1)) && (rd_ptr_ff <= PTR_W'(FIFO_DEPTH - 1)))
      else $error("pointer beyond depth");

   a_no_pop_on_clear: assert property (@(posedge clock) disable iff (reset)
      step && !dec.pop_en |=> !rsp_ff.key_valid && (rsp_ff.entry == '0))
      else $error("key delivered on modifier release");

   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      step && dec.key_req && full |=> rsp_ff.overflow && ($past(count_ff) == count_ff + 1'b1))
      else $error("drop on full queue not reported");

endmodule

// ===== hw/rtl/keyboard_scancode_decoder_top.sv =====
// keyboard_scancode_decoder_top: input register, config registers, output handshake
// depends on kscd_pkg, kscd_decode and kscd_fifo
//
//   port group  dir  handshake           payload
//   req_        in   req_valid/req_stall byte_valid, scan_byte
//   rsp_        out  rsp_valid/rsp_stall key_valid, key_code, modifiers, type flags, overflow
//   csr_        in   csr_write           csr_index, csr_data
//
// one word per clock sustained while rsp_stall is low; each word gives one result, registered
// in the input register, then through decode and queue access into the result register
// reset clears flags, modifiers, pointers, fill count and restores register defaults
// a stalled result holds in the output register; the input register then takes a word only while it is empty

module keyboard_scancode_decoder_top
   import kscd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_byte_valid,
   input  logic [7:0] req_scan_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_key_valid,
   output logic [7:0] rsp_key_code,
   output logic       rsp_shift_held,
   output logic       rsp_alt_held,
   output logic       rsp_ctl_held,
   output logic       rsp_is_release,
   output logic       rsp_is_extended,
   output logic       rsp_overflow,
   input  logic       csr_write,
   input  logic [2:0] csr_index,
   input  logic [7:0] csr_data
);

   cfg_type    cfg_ff;
   logic       in_valid_ff, in_valid_in;
   logic       in_bv_ff;
   logic [7:0] in_byte_ff;
   logic       out_valid_ff, out_valid_in;
   logic       step;
   logic       in_load;
   dec_type    dec;
   rsp_type    rsp;

   always_comb begin
      step         = in_valid_ff && (!out_valid_ff || !rsp_stall);
      in_load      = !in_valid_ff || step;
      in_valid_in  = in_load ? req_valid : in_valid_ff;
      out_valid_in = step ? 1'b1 : (out_valid_ff && rsp_stall);
   end

   assign req_stall = !in_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load) begin
         in_bv_ff   <= req_byte_valid;
         in_byte_ff <= req_scan_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.release_prefix  <= RELEASE_PREFIX_RST;
         cfg_ff.extended_prefix <= EXTENDED_PREFIX_RST;
         cfg_ff.shift_code      <= SHIFT_CODE_RST;
         cfg_ff.alt_code        <= ALT_CODE_RST;
         cfg_ff.ctl_code        <= CTL_CODE_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_RELEASE_PREFIX:  cfg_ff.release_prefix  <= csr_data;
            CSR_EXTENDED_PREFIX: cfg_ff.extended_prefix <= csr_data;
            CSR_SHIFT_CODE:      cfg_ff.shift_code      <= csr_data;
            CSR_ALT_CODE:        cfg_ff.alt_code        <= csr_data;
            CSR_CTL_CODE:        cfg_ff.ctl_code        <= csr_data;
            default: begin
            end
         endcase
      end
   end

   kscd_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .cfg        (cfg_ff),
      .byte_valid (in_bv_ff),
      .scan_byte  (in_byte_ff),
      .dec        (dec)
   );

   kscd_fifo u_fifo (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .dec   (dec),
      .rsp   (rsp)
   );

   assign rsp_valid       = out_valid_ff;
   assign rsp_key_valid   = rsp.key_valid;
   assign rsp_key_code    = rsp.entry.code;
   assign rsp_shift_held  = rsp.entry.mods[0];
   assign rsp_alt_held    = rsp.entry.mods[1];
   assign rsp_ctl_held    = rsp.entry.mods[2];
   assign rsp_is_release  = rsp.entry.is_release;
   assign rsp_is_extended = rsp.entry.is_extended;
   assign rsp_overflow    = rsp.overflow;

endmodule

// ===== dv/tb_keyboard_scancode_decoder_top.sv =====
// tb_keyboard_scancode_decoder_top: self-checking testbench of the scancode decoder
// runs a directed table and then random key sequences, with idle gaps on both sides
// depends on kscd_pkg and keyboard_scancode_decoder_top

module tb_keyboard_scancode_decoder_top;
   timeunit 1ns;
   timeprecision 1ps;

   import kscd_pkg::*;

   localparam logic [2:0] CSR_UNMAPPED_LO = 3'd5;
   localparam logic [2:0] CSR_UNMAPPED_HI = 3'd7;
   localparam rsp_type    NO_KEY          = '0;
   localparam int         HOLD_CYCLES     = 64;

   typedef struct {
      logic       byte_valid;
      logic [7:0] scan_byte;
      logic       typed;
      rsp_type    want;
   } stim_row_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic       req_byte_valid = 1'b0;
   logic [7:0] req_scan_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_key_valid;
   logic [7:0] rsp_key_code;
   logic       rsp_shift_held;
   logic       rsp_alt_held;
   logic       rsp_ctl_held;
   logic       rsp_is_release;
   logic       rsp_is_extended;
   logic       rsp_overflow;
   logic       csr_write = 1'b0;
   logic [2:0] csr_index = 3'd0;
   logic [7:0] csr_data = 8'h00;

   // decoder shadow state
   cfg_type       cfg_shadow = '{RELEASE_PREFIX_RST, EXTENDED_PREFIX_RST, SHIFT_CODE_RST,
                                 ALT_CODE_RST, CTL_CODE_RST};
   logic          rel_pending = 1'b0;
   logic          ext_pending = 1'b0;
   logic [2:0]    held_mods = MOD_NONE;
   key_entry_type key_store[$];

   rsp_type      expected_keys[$];
   stim_row_type directed_rows[$];

   int send_idle_pct = 26;
   int rsp_idle_pct = 68;
   int words_sent = 0;
   int keys_seen = 0;
   int release_keys = 0;
   int extended_keys = 0;
   int mismatch_count = 0;
   int hold_left = 0;
   bit pressure_request = 1'b0;
   bit pressure_done = 1'b0;

   keyboard_scancode_decoder_top dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_byte_valid  (req_byte_valid),
      .req_scan_byte   (req_scan_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_key_valid   (rsp_key_valid),
      .rsp_key_code    (rsp_key_code),
      .rsp_shift_held  (rsp_shift_held),
      .rsp_alt_held    (rsp_alt_held),
      .rsp_ctl_held    (rsp_ctl_held),
      .rsp_is_release  (rsp_is_release),
      .rsp_is_extended (rsp_is_extended),
      .rsp_overflow    (rsp_overflow),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always #5 clock = ~clock;

   function automatic rsp_type key_word(logic [7:0] code, logic [2:0] mods, logic rel,
                                        logic ext);
      rsp_type res;
      res                   = '0;
      res.key_valid         = 1'b1;
      res.entry.code        = code;
      res.entry.mods        = mods;
      res.entry.is_release  = rel;
      res.entry.is_extended = ext;
      return res;
   endfunction

   function automatic stim_row_type row(logic bv, logic [7:0] sb, logic typed,
                                        rsp_type want);
      stim_row_type r;
      r.byte_valid = bv;
      r.scan_byte  = sb;
      r.typed      = typed;
      r.want       = want;
      return r;
   endfunction

   // one poll tick of the decoder: flags, modifiers, key queue, delivery
   function automatic rsp_type decode_tick(logic bv, logic [7:0] sb);
      rsp_type       res;
      logic          rel_snap;
      logic          ext_snap;
      logic [2:0]    clr;
      key_entry_type ent;
      res      = '0;
      rel_snap = rel_pending;
      ext_snap = ext_pending;
      clr      = MOD_NONE;
      if (bv) begin
         if (rel_pending) begin
            rel_pending = 1'b0;
            if (sb == cfg_shadow.shift_code) clr = MOD_SHIFT;
            else if (sb == cfg_shadow.alt_code) clr = MOD_ALT;
            else if (sb == cfg_shadow.ctl_code) clr = MOD_CTL;
            if (clr != MOD_NONE) begin
               held_mods = held_mods & ~clr;
               return res;
            end
         end
         ext_pending = 1'b0;
         if (sb == cfg_shadow.extended_prefix) begin
            ext_pending = 1'b1;
         end else if (sb == cfg_shadow.release_prefix) begin
            rel_pending = 1'b1;
         end else if (sb == cfg_shadow.shift_code) begin
            held_mods = held_mods | MOD_SHIFT;
         end else if (sb == cfg_shadow.alt_code) begin
            held_mods = held_mods | MOD_ALT;
         end else if (sb == cfg_shadow.ctl_code) begin
            held_mods = held_mods | MOD_CTL;
         end else if (key_store.size() >= FIFO_DEPTH) begin
            res.overflow = 1'b1;
         end else begin
            ent.code        = sb;
            ent.mods        = held_mods;
            ent.is_release  = rel_snap;
            ent.is_extended = ext_snap;
            key_store.push_back(ent);
         end
      end
      if (key_store.size() != 0) begin
         res.key_valid = 1'b1;
         res.entry     = key_store.pop_front();
      end
      return res;
   endfunction

   task automatic check_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatch_count++;
      end
   endtask

   task automatic send_word(input logic bv, input logic [7:0] sb, input logic typed,
                            input rsp_type want);
      rsp_type predicted;
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(0, 99) < send_idle_pct) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_byte_valid <= bv;
      req_scan_byte  <= sb;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = decode_tick(bv, sb);
      expected_keys.push_back(typed ? want : predicted);
      words_sent++;
   endtask

   task automatic send_byte(input logic [7:0] sb);
      send_word(1'b1, sb, 1'b0, NO_KEY);
   endtask

   function automatic logic [7:0] pick_mod_code();
      case ($urandom_range(0, 2))
         0: return cfg_shadow.shift_code;
         1: return cfg_shadow.alt_code;
         default: return cfg_shadow.ctl_code;
      endcase
   endfunction

   // mostly well-formed press and release sequences, some noise
   task automatic send_sequence();
      case ($urandom_range(0, 9))
         0, 1, 2: begin
            if ($urandom_range(0, 3) == 0) send_byte(cfg_shadow.extended_prefix);
            send_byte(8'($urandom_range(0, 255)));
         end
         3, 4: begin
            if ($urandom_range(0, 3) == 0) send_byte(cfg_shadow.extended_prefix);
            send_byte(cfg_shadow.release_prefix);
            send_byte(8'($urandom_range(0, 255)));
         end
         5: send_byte(pick_mod_code());
         6: begin
            send_byte(cfg_shadow.release_prefix);
            send_byte(pick_mod_code());
         end
         7: send_word(1'b0, 8'($urandom_range(0, 255)), 1'b0, NO_KEY);
         default: send_byte(8'($urandom_range(0, 255)));
      endcase
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_keys.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [7:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      case (idx)
         CSR_RELEASE_PREFIX:  cfg_shadow.release_prefix = data;
         CSR_EXTENDED_PREFIX: cfg_shadow.extended_prefix = data;
         CSR_SHIFT_CODE:      cfg_shadow.shift_code = data;
         CSR_ALT_CODE:        cfg_shadow.alt_code = data;
         CSR_CTL_CODE:        cfg_shadow.ctl_code = data;
         default: ;
      endcase
   endtask

   task automatic run_phase(input int n_words, input int snd_pct, input int rcv_pct);
      int stop_at;
      send_idle_pct = snd_pct;
      rsp_idle_pct  = rcv_pct;
      stop_at       = words_sent + n_words;
      while (words_sent < stop_at) send_sequence();
      drain();
   endtask

   always @(posedge clock) begin : rsp_side
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.key_valid         = rsp_key_valid;
         got.overflow          = rsp_overflow;
         got.entry.code        = rsp_key_code;
         got.entry.mods        = {rsp_ctl_held, rsp_alt_held, rsp_shift_held};
         got.entry.is_release  = rsp_is_release;
         got.entry.is_extended = rsp_is_extended;
         if (expected_keys.size() == 0) begin
            $error("unexpected result word: key_valid %0b code %0h", rsp_key_valid,
                   rsp_key_code);
            mismatch_count++;
         end else begin
            want = expected_keys.pop_front();
            check_field("key_valid", 8'(want.key_valid), 8'(got.key_valid));
            check_field("key_code", want.entry.code, got.entry.code);
            check_field("shift_held", 8'(want.entry.mods[0]), 8'(got.entry.mods[0]));
            check_field("alt_held", 8'(want.entry.mods[1]), 8'(got.entry.mods[1]));
            check_field("ctl_held", 8'(want.entry.mods[2]), 8'(got.entry.mods[2]));
            check_field("is_release", 8'(want.entry.is_release),
                        8'(got.entry.is_release));
            check_field("is_extended", 8'(want.entry.is_extended),
                        8'(got.entry.is_extended));
            check_field("overflow", 8'(want.overflow), 8'(got.overflow));
         end
         if (got.key_valid) begin
            keys_seen++;
            if (got.entry.is_release) release_keys++;
            if (got.entry.is_extended) extended_keys++;
         end
      end
      // long hold-off so the decoder backs up into its input
      if (pressure_request && !pressure_done) begin
         hold_left     = HOLD_CYCLES;
         pressure_done = 1'b1;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < rsp_idle_pct);
      end
   end

   initial begin
      #2_000_000;
      $display("** keyboard_scancode_decoder_top: FAILED **");
      $finish;
   end

   initial begin
      // reset settings: release F0, extended E0, shift 12, alt 11, ctl 14
      directed_rows.push_back(row(1'b0, 8'hFF, 1'b1, NO_KEY));
      directed_rows.push_back(row(1'b1, 8'h00, 1'b1, key_word(8'h00, MOD_NONE, 1'b0, 1'b0)));
      directed_rows.push_back(row(1'b1, 8'hFF, 1'b1, key_word(8'hFF, MOD_NONE, 1'b0, 1'b0)));
      directed_rows.push_back(row(1'b1, 8'hE0, 1'b1, NO_KEY));
      directed_rows.push_back(row(1'b1, 8'h75, 1'b1, key_word(8'h75, MOD_NONE, 1'b0, 1'b1)));
      directed_rows.push_back(row(1'b1, 8'h12, 1'b1, NO_KEY));
      directed_rows.push_back(row(1'b1, 8'h1C, 1'b0, NO_KEY));
      directed_rows.push_back(row(1'b1, 8'h11, 1'b1, NO_KEY));
      directed_rows.push_back(row(1'b1, 8'h14, 1'b1, NO_KEY));
      directed_rows.push_back(row(1'b1, 8'h2A, 1'b0, NO_KEY));
      directed_rows.push_back(row(1'b1, 8'hF0, 1'b1, NO_KEY));
      directed_rows.push_back(row(1'b1, 8'h12, 1'b1, NO_KEY));
      directed_rows.push_back(row(1'b1, 8'hF0, 1'b1, NO_KEY));
      directed_rows.push_back(row(1'b0, 8'h00, 1'b0, NO_KEY));
      directed_rows.push_back(row(1'b1, 8'h3C, 1'b0, NO_KEY));
      directed_rows.push_back(row(1'b1, 8'hE0, 1'b1, NO_KEY));
      directed_rows.push_back(row(1'b1, 8'hF0, 1'b1, NO_KEY));
      directed_rows.push_back(row(1'b1, 8'h6B, 1'b0, NO_KEY));
      directed_rows.push_back(row(1'b1, 8'hF0, 1'b1, NO_KEY));
      directed_rows.push_back(row(1'b1, 8'hE0, 1'b1, NO_KEY));
      directed_rows.push_back(row(1'b1, 8'h74, 1'b0, NO_KEY));
      directed_rows.push_back(row(1'b1, 8'hF0, 1'b1, NO_KEY));
      directed_rows.push_back(row(1'b1, 8'h14, 1'b1, NO_KEY));
      directed_rows.push_back(row(1'b1, 8'hF0, 1'b1, NO_KEY));
      directed_rows.push_back(row(1'b1, 8'h11, 1'b1, NO_KEY));

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         send_word(directed_rows[i].byte_valid, directed_rows[i].scan_byte,
                   directed_rows[i].typed, directed_rows[i].want);
      drain();

      // extreme codes 00 and FF, shift and alt on one code, unmapped index ignored
      write_reg(CSR_RELEASE_PREFIX, 8'h00);
      write_reg(CSR_EXTENDED_PREFIX, 8'hFF);
      write_reg(CSR_SHIFT_CODE, 8'h01);
      write_reg(CSR_ALT_CODE, 8'h01);
      write_reg(CSR_CTL_CODE, 8'hFE);
      write_reg(CSR_UNMAPPED_LO, 8'hAA);
      csr_write <= 1'b0;
      run_phase(225, 26, 68);

      // every register on the same code
      write_reg(CSR_RELEASE_PREFIX, 8'hFF);
      write_reg(CSR_EXTENDED_PREFIX, 8'hFF);
      write_reg(CSR_SHIFT_CODE, 8'hFF);
      write_reg(CSR_ALT_CODE, 8'hFF);
      write_reg(CSR_CTL_CODE, 8'hFF);
      write_reg(CSR_UNMAPPED_HI, 8'h00);
      csr_write <= 1'b0;
      run_phase(225, 68, 26);

      write_reg(CSR_RELEASE_PREFIX, 8'($urandom_range(0, 255)));
      write_reg(CSR_EXTENDED_PREFIX, 8'($urandom_range(0, 255)));
      write_reg(CSR_SHIFT_CODE, 8'($urandom_range(0, 255)));
      write_reg(CSR_ALT_CODE, 8'($urandom_range(0, 255)));
      write_reg(CSR_CTL_CODE, 8'($urandom_range(0, 255)));
      csr_write <= 1'b0;
      pressure_request = 1'b1;
      run_phase(250, 0, 0);

      repeat (6) @(posedge clock);
      $display("covered %0d words under four register settings and three idle patterns",
               words_sent);
      $display("delivered %0d keys, %0d of them release and %0d extended",
               keys_seen, release_keys, extended_keys);
      if (mismatch_count == 0) begin
         $display("** keyboard_scancode_decoder_top: PASSED **");
      end else begin
         $display("** keyboard_scancode_decoder_top: FAILED **");
      end
      $finish;
   end

endmodule
